@@ hdl/mabs_pkg.sv @@
// shared types and constants for the four-axis bresenham step generator
// no dependencies
package mabs_pkg;

	localparam int STEP_BITS = 24;
	localparam int POS_BITS  = 32;
	localparam int ERR_BITS  = STEP_BITS + 1;
	localparam int DIFF_BITS = STEP_BITS + 2;
	localparam int CFG_BITS  = 24;
	localparam int IDX_BITS  = 3;
	localparam int NUM_AXES  = 4;

	localparam int AXIS_X = 0;
	localparam int AXIS_Y = 1;
	localparam int AXIS_Z = 2;
	localparam int AXIS_E = 3;

	typedef enum logic [IDX_BITS-1:0] {
		REG_DELTA_X     = 3'd0,
		REG_DELTA_Y     = 3'd1,
		REG_DELTA_Z     = 3'd2,
		REG_DELTA_E     = 3'd3,
		REG_DIRECTION   = 3'd4,
		REG_HOMING      = 3'd5,
		REG_HOME_Y_POS  = 3'd6
	} reg_idx_t;

	localparam logic MODE_START = 1'b0;
	localparam logic MODE_TICK  = 1'b1;

	typedef struct packed {
		logic mode;
		logic x_stop;
		logic y_stop;
		logic z_stop;
	} in_item_t;

	typedef struct packed {
		logic [3:0]         step_mask;
		logic               active;
		logic               move_done;
		logic signed [31:0] position_x;
		logic signed [31:0] position_y;
		logic signed [31:0] position_z;
		logic signed [31:0] position_e;
	} out_item_t;

	typedef struct packed {
		logic [NUM_AXES-1:0][STEP_BITS-1:0] delta;
		logic [NUM_AXES-1:0]                dir;
		logic                               homing;
		logic                               home_y_pos;
	} cfg_t;

	typedef struct packed {
		logic                 load;
		logic                 tick;
		logic                 blocked;
		logic                 dir;
		logic [STEP_BITS-1:0] load_delta;
		logic [STEP_BITS-1:0] len;
	} axis_ctrl_t;

endpackage

@@ hdl/mabs_cfg_regs.sv @@
// configuration register file: step counts, directions, homing options
// depends on mabs_pkg
module mabs_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [mabs_pkg::IDX_BITS-1:0]   wr_index,
	input  logic [mabs_pkg::CFG_BITS-1:0]   wr_data,
	output mabs_pkg::cfg_t                  cfg
);

	mabs_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				mabs_pkg::REG_DELTA_X:
					cfg_q.delta[mabs_pkg::AXIS_X] <= mabs_pkg::STEP_BITS'(wr_data);
				mabs_pkg::REG_DELTA_Y:
					cfg_q.delta[mabs_pkg::AXIS_Y] <= mabs_pkg::STEP_BITS'(wr_data);
				mabs_pkg::REG_DELTA_Z:
					cfg_q.delta[mabs_pkg::AXIS_Z] <= mabs_pkg::STEP_BITS'(wr_data);
				mabs_pkg::REG_DELTA_E:
					cfg_q.delta[mabs_pkg::AXIS_E] <= mabs_pkg::STEP_BITS'(wr_data);
				mabs_pkg::REG_DIRECTION:  cfg_q.dir        <= wr_data[3:0];
				mabs_pkg::REG_HOMING:     cfg_q.homing     <= wr_data[0];
				mabs_pkg::REG_HOME_Y_POS: cfg_q.home_y_pos <= wr_data[0];
				default: ; // unused index, ignored
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ hdl/mabs_axis.sv @@
// one axis of the dda: error counter, steps left and position
// depends on mabs_pkg
module mabs_axis (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mabs_pkg::axis_ctrl_t          ctrl,
	output logic                          step,
	output logic [mabs_pkg::POS_BITS-1:0] pos_next
);

	logic signed [mabs_pkg::ERR_BITS-1:0]  err_q, err_d;
	logic        [mabs_pkg::STEP_BITS-1:0] left_q, left_d;
	logic        [mabs_pkg::STEP_BITS-1:0] delta_q, delta_d;
	logic        [mabs_pkg::POS_BITS-1:0]  pos_q;
	logic signed [mabs_pkg::DIFF_BITS-1:0] diff;
	logic signed [mabs_pkg::DIFF_BITS-1:0] back;
	logic                                  can_move;

	always_comb begin
		diff     = mabs_pkg::DIFF_BITS'(err_q) - $signed({2'b00, delta_q});
		back     = diff + $signed({2'b00, ctrl.len});
		can_move = ctrl.tick && (left_q != '0) && !ctrl.blocked;
		step     = can_move && diff[mabs_pkg::DIFF_BITS-1];
		err_d    = err_q;
		left_d   = left_q;
		delta_d  = delta_q;
		pos_next = pos_q;
		if (ctrl.load) begin
			// preload to minus half the move length
			err_d   = -$signed({1'b0, ctrl.len >> 1});
			left_d  = ctrl.load_delta;
			delta_d = ctrl.load_delta;
		end else if (can_move) begin
			if (step) begin
				err_d    = mabs_pkg::ERR_BITS'(back);
				left_d   = left_q - 1'b1;
				pos_next = ctrl.dir ? pos_q + 1'b1 : pos_q - 1'b1;
			end else begin
				err_d = mabs_pkg::ERR_BITS'(diff);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q   <= '0;
			left_q  <= '0;
			delta_q <= '0;
			pos_q   <= '0;
		end else begin
			err_q   <= err_d;
			left_q  <= left_d;
			delta_q <= delta_d;
			pos_q   <= pos_next;
		end
	end

endmodule

@@ hdl/mabs_out_buf.sv @@
// result register with a skid stage behind it
// depends on mabs_pkg
module mabs_out_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  mabs_pkg::out_item_t push_item,
	output logic                full,
	output logic                out_valid,
	input  logic                out_stall,
	output mabs_pkg::out_item_t out_item
);

	logic                main_valid_q, skid_valid_q;
	mabs_pkg::out_item_t main_q, skid_q;
	logic                drain;

	assign drain     = main_valid_q && !out_stall;
	assign full      = skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_item  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (drain) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (!main_valid_q || drain) begin
				main_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (drain) begin
			main_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (drain) begin
				main_q <= skid_q;
			end
		end else if (push) begin
			if (!main_valid_q || drain) begin
				main_q <= push_item;
			end else begin
				skid_q <= push_item;
			end
		end
	end

endmodule

@@ hdl/multi_axis_bresenham_stepper.sv @@
// top level of the four-axis bresenham step generator
// depends on mabs_pkg, mabs_cfg_regs, mabs_axis, mabs_out_buf
//
// channel   | signals                     | direction | carries
// ----------+-----------------------------+-----------+-------------------------------
// input     | in_valid, in_stall, in_item | in        | start or step tick, endstops
// result    | out_valid, out_stall, out_item | out    | step mask, state, positions
// config    | wr_en, wr_index, wr_data    | in        | counts, directions, homing
//
// one item per clock while in_stall is low: each item is handled in the cycle it
// is accepted, the four axis add-compare updates in parallel set the cycle time
// each result is registered in the output register; a skid stage keeps
// input open while a result is stalled, in_stall rises only when both are full
// reset clears the config, counters, positions and valid flags to zero with no move running
module multi_axis_bresenham_stepper (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  mabs_pkg::in_item_t            in_item,
	output logic                          out_valid,
	input  logic                          out_stall,
	output mabs_pkg::out_item_t           out_item,
	input  logic                          wr_en,
	input  logic [mabs_pkg::IDX_BITS-1:0] wr_index,
	input  logic [mabs_pkg::CFG_BITS-1:0] wr_data
);

	mabs_pkg::cfg_t       cfg;
	mabs_pkg::axis_ctrl_t ctrl [mabs_pkg::NUM_AXES];
	mabs_pkg::out_item_t  result;

	logic                                                buf_full;
	logic                                                accept;
	logic                                                start;
	logic                                                tick;
	logic                                                start_ok;
	logic [mabs_pkg::STEP_BITS-1:0]                      max_xy, max_ze, new_len;
	logic [mabs_pkg::NUM_AXES-1:0]                       step;
	logic [mabs_pkg::NUM_AXES-1:0][mabs_pkg::POS_BITS-1:0] pos_next;
	logic [mabs_pkg::NUM_AXES-1:0]                       stop_hit;
	logic [mabs_pkg::NUM_AXES-1:0]                       blocked;
	logic                                                running_d;
	logic                                                done;

	// move parameters latched at start
	logic                           running_q;
	logic [mabs_pkg::STEP_BITS-1:0] len_q;
	logic [mabs_pkg::NUM_AXES-1:0]  dir_q;
	logic                           homing_q;
	logic                           home_y_q;

	mabs_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	assign in_stall = buf_full;
	assign accept   = in_valid && !buf_full;
	assign start    = accept && (in_item.mode == mabs_pkg::MODE_START);
	assign tick     = accept && (in_item.mode == mabs_pkg::MODE_TICK) && running_q;

	// move length is the largest of the four counts
	always_comb begin
		max_xy   = (cfg.delta[mabs_pkg::AXIS_X] > cfg.delta[mabs_pkg::AXIS_Y]) ?
			cfg.delta[mabs_pkg::AXIS_X] : cfg.delta[mabs_pkg::AXIS_Y];
		max_ze   = (cfg.delta[mabs_pkg::AXIS_Z] > cfg.delta[mabs_pkg::AXIS_E]) ?
			cfg.delta[mabs_pkg::AXIS_Z] : cfg.delta[mabs_pkg::AXIS_E];
		new_len  = (max_xy > max_ze) ? max_xy : max_ze;
		// a zero length start never runs and leaves the axes alone
		start_ok = start && (new_len != '0);
	end

	// endstop gating in homing moves: x and z block toward minus,
	// y blocks toward its home side, e is never blocked
	always_comb begin
		stop_hit = {1'b0, in_item.z_stop, in_item.y_stop, in_item.x_stop};
		blocked[mabs_pkg::AXIS_X] = homing_q && stop_hit[mabs_pkg::AXIS_X] &&
			!dir_q[mabs_pkg::AXIS_X];
		blocked[mabs_pkg::AXIS_Y] = homing_q && stop_hit[mabs_pkg::AXIS_Y] &&
			(dir_q[mabs_pkg::AXIS_Y] == home_y_q);
		blocked[mabs_pkg::AXIS_Z] = homing_q && stop_hit[mabs_pkg::AXIS_Z] &&
			!dir_q[mabs_pkg::AXIS_Z];
		blocked[mabs_pkg::AXIS_E] = 1'b0;
	end

	for (genvar a = 0; a < mabs_pkg::NUM_AXES; a++) begin : g_axis
		always_comb begin
			ctrl[a].load       = start_ok;
			ctrl[a].tick       = tick;
			ctrl[a].blocked    = blocked[a];
			ctrl[a].dir        = dir_q[a];
			ctrl[a].load_delta = cfg.delta[a];
			ctrl[a].len        = start_ok ? new_len : len_q;
		end

		mabs_axis u_axis (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl[a]),
			.step     (step[a]),
			.pos_next (pos_next[a])
		);
	end

	// a running tick with no step at all ends the move
	always_comb begin
		done      = tick && (step == '0);
		running_d = running_q;
		if (start) begin
			running_d = start_ok;
		end else if (done) begin
			running_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			len_q     <= '0;
			dir_q     <= '0;
			homing_q  <= 1'b0;
			home_y_q  <= 1'b0;
		end else begin
			running_q <= running_d;
			if (start_ok) begin
				len_q    <= new_len;
				dir_q    <= cfg.dir;
				homing_q <= cfg.homing;
				home_y_q <= cfg.home_y_pos;
			end
		end
	end

	// result item: positions after this item, low 32 bits
	always_comb begin
		result.step_mask  = step;
		result.active     = running_d;
		result.move_done  = done;
		result.position_x = 32'(pos_next[mabs_pkg::AXIS_X]);
		result.position_y = 32'(pos_next[mabs_pkg::AXIS_Y]);
		result.position_z = 32'(pos_next[mabs_pkg::AXIS_Z]);
		result.position_e = 32'(pos_next[mabs_pkg::AXIS_E]);
	end

	mabs_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_item (result),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule
